[rtl/assert_macros.svh]
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SPS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[rtl/sps_pkg.sv]
// ------------------------------------------------------------------------
// sps_pkg
// Shared constants and types for the solenoid pulse sequencer.
// ------------------------------------------------------------------------
package sps_pkg;

  // channel count and derived widths
  localparam int CHANNELS = 16;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // item field widths
  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int VELO_W  = 16;
  localparam int COUNT_W = 15;
  localparam int MASK_W  = 16;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_NOTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  // channel field select and stop-all off mask
  localparam logic [CHAN_W-1:0] CHAN_SEL = CHAN_W'(CHANNELS - 1);
  localparam logic [MASK_W-1:0] ALL_OFF_MASK =
    (CHANNELS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << CHANNELS) - 64'd1);

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input beat
    logic exec;     // note / stop / tick setup
    logic step;     // process one channel of a tick
    logic publish;  // move working masks to the output register
  } sps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic walk_last;
    logic out_busy;
  } sps_status_t;

endpackage

[rtl/solenoid_pulse_sequencer_unit.sv]
// ------------------------------------------------------------------------
// solenoid_pulse_sequencer_unit
// Multi-channel solenoid pulse timer: note, tick and stop-all beats.
// ------------------------------------------------------------------------
// Flow: a beat is captured on acceptance, set up in S_EXEC, walked in
//   S_WALK (tick only) and published from S_FINISH once out_valid is clear
//   or being taken; a new beat is accepted only in S_IDLE, after publish.
//   A tick walks the channel store one channel per cycle.
// Reset: rst clears all channel flags, the controller and out_valid.
module solenoid_pulse_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sps_pkg::MODE_W-1:0]   mode,
  input  logic [sps_pkg::CHAN_W-1:0]   channel,
  input  logic [sps_pkg::VELO_W-1:0]   velocity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sps_pkg::MASK_W-1:0]   full_mask,
  output logic [sps_pkg::MASK_W-1:0]   hold_mask,
  output logic [sps_pkg::MASK_W-1:0]   off_mask
);
  import sps_pkg::*;

  sps_cmd_t    cmd;
  sps_status_t status;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (mode),
    .channel   (channel),
    .velocity  (velocity),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .full_mask (full_mask),
    .hold_mask (hold_mask),
    .off_mask  (off_mask)
  );

endmodule

[rtl/sps_ctrl.sv]
// ------------------------------------------------------------------------
// sps_ctrl
// Sequencer controller: accepts a beat, runs it, hands off the result.
// ------------------------------------------------------------------------
module sps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  sps_pkg::sps_status_t status,
  output sps_pkg::sps_cmd_t    cmd
);
  import sps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   can_publish;

  assign can_publish = !status.out_busy || out_ready;
  assign in_ready    = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.is_tick ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (can_publish) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/sps_datapath.sv]
// ------------------------------------------------------------------------
// sps_datapath
// Channel store, flags, tick walker and output register.
// ------------------------------------------------------------------------
module sps_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  sps_pkg::sps_cmd_t            cmd,
  output sps_pkg::sps_status_t         status,
  input  logic [sps_pkg::MODE_W-1:0]   mode,
  input  logic [sps_pkg::CHAN_W-1:0]   channel,
  input  logic [sps_pkg::VELO_W-1:0]   velocity,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [sps_pkg::MASK_W-1:0]   full_mask,
  output logic [sps_pkg::MASK_W-1:0]   hold_mask,
  output logic [sps_pkg::MASK_W-1:0]   off_mask
);
  import sps_pkg::*;

  // latched item
  logic [MODE_W-1:0]  item_mode;
  logic [CHAN_W-1:0]  item_chan;
  logic [VELO_W-1:0]  item_velo;

  // per-channel state
  logic [COUNT_W-1:0] pulse_count [CHANNELS];
  logic [CHANNELS-1:0] trigger_flag;
  logic [CHANNELS-1:0] play_flag;

  // walk index and working masks
  logic [IDX_W-1:0]   idx;
  logic [MASK_W-1:0]  work_full;
  logic [MASK_W-1:0]  work_hold;
  logic [MASK_W-1:0]  work_off;

  // note decode
  logic [CHAN_W-1:0]  chan_m;
  logic [IDX_W-1:0]   note_idx;
  logic               note_in_range;
  logic               note_off;
  logic               do_note;

  // tick channel evaluation
  logic [COUNT_W-1:0] cnt_rd;
  logic [COUNT_W-1:0] cnt_dec;
  logic [MASK_W-1:0]  walk_bit;
  logic               walk_play;
  logic               walk_trig;

  assign chan_m        = item_chan & CHAN_SEL;
  assign note_idx      = IDX_W'(chan_m);
  assign note_in_range = (8'(chan_m) < 8'(CHANNELS));
  assign note_off      = (item_velo == '0) || item_velo[VELO_W-1];
  assign do_note       = cmd.exec && (item_mode == MODE_NOTE) && note_in_range;

  assign cnt_rd    = pulse_count[idx];
  assign cnt_dec   = cnt_rd - COUNT_W'(1);
  assign walk_bit  = MASK_W'(1) << idx;
  assign walk_play = play_flag[idx];
  assign walk_trig = trigger_flag[idx];

  assign status.is_tick   = (item_mode == MODE_TICK);
  assign status.walk_last = (idx == IDX_W'(CHANNELS - 1));
  assign status.out_busy  = out_valid;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= mode;
      item_chan <= channel;
      item_velo <= velocity;
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_flag <= '0;
      play_flag    <= '0;
    end else if (cmd.exec && item_mode == MODE_STOP) begin
      trigger_flag <= '0;
      play_flag    <= '0;
    end else if (do_note) begin
      if (note_off) begin
        trigger_flag[note_idx] <= 1'b0;
        play_flag[note_idx]    <= 1'b0;
      end else begin
        trigger_flag[note_idx] <= 1'b1;
      end
    end else if (cmd.step) begin
      if (walk_play) begin
        if (cnt_dec == '0) begin
          play_flag[idx] <= 1'b0;
        end
      end else if (walk_trig) begin
        trigger_flag[idx] <= 1'b0;
        play_flag[idx]    <= 1'b1;
      end
    end
  end

  // pulse count store
  always_ff @(posedge clk) begin
    if (cmd.exec && item_mode == MODE_STOP) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_count[i] <= '0;
      end
    end else if (do_note && !note_off) begin
      pulse_count[note_idx] <= item_velo[COUNT_W-1:0];
    end else if (cmd.step && walk_play) begin
      pulse_count[idx] <= cnt_dec;
    end
  end

  // walk index and working masks
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx       <= '0;
      work_full <= '0;
      work_hold <= '0;
      work_off  <= '0;
      if (item_mode == MODE_STOP) begin
        work_off <= ALL_OFF_MASK;
      end else if (do_note && note_off) begin
        work_off <= MASK_W'(1) << chan_m;
      end
    end else if (cmd.step) begin
      idx <= idx + IDX_W'(1);
      if (walk_play) begin
        if (cnt_dec == '0) begin
          work_hold <= work_hold | walk_bit;
        end
      end else if (walk_trig) begin
        work_full <= work_full | walk_bit;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      full_mask <= work_full;
      hold_mask <= work_hold;
      off_mask  <= work_off;
    end
  end

endmodule

[rtl/sps_checker.sv]
// ------------------------------------------------------------------------
// sps_checker
// Port-level checks for the sequencer, bound to the top level.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sps_pkg::MASK_W-1:0]   full_mask,
  input logic [sps_pkg::MASK_W-1:0]   hold_mask,
  input logic [sps_pkg::MASK_W-1:0]   off_mask
);

  // result beat holds until taken
  `SPS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // one beat in flight: ready falls after an accepted beat
  `SPS_ASSERT(a_one_beat, clk, rst, in_valid && in_ready |=> !in_ready, "second beat taken")

  // a channel never starts and drops in the same tick
  `SPS_ASSERT(a_full_hold, clk, rst, out_valid |-> (full_mask & hold_mask) == '0, "full and hold overlap")

  // off results carry no drive changes
  `SPS_ASSERT(a_off_only, clk, rst, out_valid && off_mask != '0 |-> full_mask == '0 && hold_mask == '0, "off mixed with drive")

  // reset empties the output register
  `SPS_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "out_valid after reset")

endmodule

bind solenoid_pulse_sequencer_unit sps_checker u_sps_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top
// Regression bench for the solenoid pulse sequencer. A behavioral model of
// the per-channel flags and counters predicts the full/hold/off masks for
// each beat. Every output beat is checked against the oldest prediction.
// Directed cases come first, then weighted random traffic with random
// sender bursts, a receiver stall pattern and one long output hold-off.
// ------------------------------------------------------------------------
module tb_top;
  import sps_pkg::*;

  // mode code the block does not define
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // largest velocity that still arms a channel
  localparam logic [VELO_W-1:0] NOTE_ON_MAX = 16'h7FFF;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int TAIL_CYCLES     = 2 * (CHANNELS + 3);
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRINT_LIMIT     = 40;

  typedef struct packed {
    logic [MASK_W-1:0] full_bits;
    logic [MASK_W-1:0] hold_bits;
    logic [MASK_W-1:0] off_bits;
  } drive_masks_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAN_W-1:0]   channel;
  logic [VELO_W-1:0]   velocity;
  logic                out_valid;
  logic                out_ready;
  logic [MASK_W-1:0]   full_mask;
  logic [MASK_W-1:0]   hold_mask;
  logic [MASK_W-1:0]   off_mask;

  // channel model state
  logic [COUNT_W-1:0]  ch_count [CHANNELS];
  bit                  ch_armed [CHANNELS];
  bit                  ch_playing [CHANNELS];
  bit                  ch_holding [CHANNELS];

  drive_masks_t        expected_masks [$];
  int                  mismatch_count;
  int                  burst_left;
  int                  stall_cycles;
  logic                hold_off_req;

  solenoid_pulse_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .channel   (channel),
    .velocity  (velocity),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .full_mask (full_mask),
    .hold_mask (hold_mask),
    .off_mask  (off_mask)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // clear every channel's count and flags
  function automatic void clear_channel_model();
    for (int i = 0; i < CHANNELS; i++) begin
      ch_count[i]   = '0;
      ch_armed[i]   = 1'b0;
      ch_playing[i] = 1'b0;
      ch_holding[i] = 1'b0;
    end
  endfunction

  // advance the channel model by one beat and return the drive changes
  function automatic drive_masks_t predict_drive_masks(logic [MODE_W-1:0] m,
                                                       logic [CHAN_W-1:0] c,
                                                       logic [VELO_W-1:0] v);
    drive_masks_t r;
    int           idx;
    r   = '0;
    idx = int'(c & CHAN_SEL);
    case (m)
      MODE_NOTE: begin
        if (idx < CHANNELS) begin
          if (v == '0 || v > NOTE_ON_MAX) begin
            // note off keeps the count
            ch_armed[idx]   = 1'b0;
            ch_playing[idx] = 1'b0;
            ch_holding[idx] = 1'b0;
            if (idx < MASK_W) r.off_bits[idx] = 1'b1;
          end else begin
            ch_count[idx] = v[COUNT_W-1:0];
            ch_armed[idx] = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_playing[i]) begin
            // 15-bit countdown, wraps from zero
            ch_count[i] = ch_count[i] - 1'b1;
            if (ch_count[i] == '0) begin
              ch_playing[i] = 1'b0;
              if (i < MASK_W) r.hold_bits[i] = 1'b1;
            end
          end else if (ch_armed[i]) begin
            ch_armed[i]   = 1'b0;
            ch_playing[i] = 1'b1;
            ch_holding[i] = 1'b1;
            if (i < MASK_W) r.full_bits[i] = 1'b1;
          end
        end
      end
      MODE_STOP: begin
        clear_channel_model();
        for (int i = 0; i < CHANNELS && i < MASK_W; i++) r.off_bits[i] = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                 input logic [MASK_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // offer one beat; valid stays up until it is taken
  task automatic send_beat(input logic [MODE_W-1:0] m, input logic [CHAN_W-1:0] c,
                           input logic [VELO_W-1:0] v);
    in_valid <= 1'b1;
    mode     <= m;
    channel  <= c;
    velocity <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_masks.push_back(predict_drive_masks(m, c, v));
  endtask

  // sender bursts: random length, random gap between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // weighted random beat: mostly short notes and ticks so channels cycle
  task automatic send_random_beat();
    int                pick;
    logic [MODE_W-1:0] m;
    logic [CHAN_W-1:0] c;
    logic [VELO_W-1:0] v;
    pick = $urandom_range(0, 99);
    c    = CHAN_W'($urandom_range(0, 15));
    m    = MODE_NOTE;
    v    = VELO_W'($urandom_range(1, 6));
    if (pick < 12) begin
      v = VELO_W'($urandom_range(1, 40));
    end else if (pick < 40) begin
      // short note already set above
    end else if (pick < 46) begin
      v = VELO_W'($urandom_range(1, 32'h7FFF));
    end else if (pick < 48) begin
      v = ($urandom_range(0, 1) == 0) ? NOTE_ON_MAX : 16'h8000;
    end else if (pick < 56) begin
      v = ($urandom_range(0, 2) == 0) ? '0 : VELO_W'($urandom_range(32'h8000, 32'hFFFF));
    end else if (pick < 92) begin
      m = MODE_TICK;
      v = VELO_W'($urandom);
    end else if (pick < 95) begin
      m = MODE_STOP;
      v = VELO_W'($urandom);
    end else begin
      m = MODE_UNUSED;
      v = VELO_W'($urandom);
    end
    send_beat(m, c, v);
  endtask

  task automatic wait_for_drain();
    while (expected_masks.size() != 0) @(posedge clk);
  endtask

  // ---------------- test tasks ----------------

  task automatic test_unused_mode();
    send_beat(MODE_UNUSED, 4'd15, 16'hFFFF);
    send_beat(MODE_UNUSED, 4'd0, 16'h0000);
  endtask

  task automatic test_note_off_forms();
    send_beat(MODE_NOTE, 4'd0, 16'h0000);
    send_beat(MODE_NOTE, 4'd15, 16'h8000);
    send_beat(MODE_NOTE, 4'd5, 16'hFFFF);
    // arm then cancel before any tick: nothing should fire
    send_beat(MODE_NOTE, 4'd3, 16'd3);
    send_beat(MODE_NOTE, 4'd3, 16'h0000);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
  endtask

  task automatic test_note_on_extremes();
    send_beat(MODE_NOTE, 4'd0, 16'd1);
    send_beat(MODE_NOTE, 4'd15, NOTE_ON_MAX);
    send_beat(MODE_TICK, 4'd9, 16'h5555);
    send_beat(MODE_TICK, 4'd6, 16'hAAAA);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
  endtask

  // overwrite while playing, re-fire with a zero count, then wrap
  task automatic test_retrigger_wrap();
    send_beat(MODE_NOTE, 4'd7, 16'd2);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
    send_beat(MODE_NOTE, 4'd7, 16'd1);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
  endtask

  task automatic test_stop_all();
    send_beat(MODE_STOP, 4'd10, 16'h1234);
    send_beat(MODE_TICK, 4'd0, 16'h0000);
  endtask

  task automatic test_random_traffic(input int beats);
    repeat (beats) begin
      pace_sender();
      send_random_beat();
    end
  endtask

  // long receiver hold-off while beats keep coming back to back
  task automatic test_output_backpressure();
    hold_off_req <= 1'b1;
    repeat (40) send_random_beat();
  endtask

  // sender goes quiet until every result is back, then resumes
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    wait_for_drain();
    @(posedge clk);
    repeat (20) send_random_beat();
  endtask

  // receiver: own stall pattern, plus a one-shot long hold-off
  initial begin : receiver
    int unsigned phase;
    out_ready = 1'b0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_req <= 1'b0;
      end else begin
        case (phase[7:6])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
          2'd2:    out_ready <= ($urandom_range(0, 9) < 4);
          default: out_ready <= (phase % 3 == 0);
        endcase
        phase++;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    drive_masks_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_masks.size() == 0) begin
        report_mismatch("beat with nothing pending", full_mask, '0);
      end else begin
        want = expected_masks.pop_front();
        if (full_mask !== want.full_bits) report_mismatch("full_mask", full_mask, want.full_bits);
        if (hold_mask !== want.hold_bits) report_mismatch("hold_mask", hold_mask, want.hold_bits);
        if (off_mask !== want.off_bits) report_mismatch("off_mask", off_mask, want.off_bits);
      end
    end
  end

  // watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("solenoid_pulse_sequencer_unit regression: fail");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_NOTE;
    channel        = '0;
    velocity       = '0;
    hold_off_req   = 1'b0;
    burst_left     = 0;
    stall_cycles   = 0;
    mismatch_count = 0;
    clear_channel_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_unused_mode();
    test_note_off_forms();
    test_note_on_extremes();
    test_retrigger_wrap();
    test_stop_all();
    test_random_traffic(700);
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(680);

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("solenoid_pulse_sequencer_unit regression: pass");
    else
      $display("solenoid_pulse_sequencer_unit regression: fail");
    $finish;
  end

endmodule

[solenoid_pulse_sequencer_unit.f]
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_ctrl.sv
rtl/sps_datapath.sv
rtl/solenoid_pulse_sequencer_unit.sv
rtl/sps_checker.sv
verif/tb_top.sv
